FILE: hw/rtl/idll_pkg.sv
`timescale 1ns / 1ps

package idll_pkg;

  // Payload widths
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned NODE_W = 10;

  // Default pool size
  localparam int unsigned POOL_NODES_DEF = 1024;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [NODE_W-1:0] node_t;

  // Command codes
  localparam cmd_t CMD_ADD_HEAD  = 3'd0;
  localparam cmd_t CMD_ADD_TAIL  = 3'd1;
  localparam cmd_t CMD_MOVE_HEAD = 3'd2;
  localparam cmd_t CMD_MOVE_TAIL = 3'd3;
  localparam cmd_t CMD_REMOVE    = 3'd4;

  // Microprogram step addresses
  typedef logic [2:0] step_t;
  localparam step_t ST_IDLE   = 3'd0;
  localparam step_t ST_DECODE = 3'd1;
  localparam step_t ST_UNL_A  = 3'd2;
  localparam step_t ST_UNL_B  = 3'd3;
  localparam step_t ST_ADD_PQ = 3'd4;
  localparam step_t ST_ADD_A  = 3'd5;
  localparam step_t ST_ADD_B  = 3'd6;
  localparam step_t ST_DONE   = 3'd7;

  // Address / data operand selects for the link memory write ports
  typedef logic [2:0] sel_t;
  localparam sel_t SEL_N  = 3'd0;  // node itself
  localparam sel_t SEL_NN = 3'd1;  // node's old next
  localparam sel_t SEL_NP = 3'd2;  // node's old prev
  localparam sel_t SEL_P  = 3'd3;  // insert predecessor
  localparam sel_t SEL_Q  = 3'd4;  // insert successor

  // Sequencer jump kinds
  typedef logic [2:0] jmp_t;
  localparam jmp_t JMP_NEXT     = 3'd0;  // step + 1
  localparam jmp_t JMP_ACCEPT   = 3'd1;  // to target on input transaction
  localparam jmp_t JMP_DISPATCH = 3'd2;  // guard/command dispatch
  localparam jmp_t JMP_MOVE     = 3'd3;  // re-add on move, else target
  localparam jmp_t JMP_OUT      = 3'd4;  // to target once result slot is free

  // One control word
  typedef struct packed {
    logic  ready;     // input channel open
    logic  capture;   // latch node links and guard
    logic  load_pq;   // latch insert neighbors
    logic  wr_en;     // write both link memories
    sel_t  nx_addr;
    sel_t  nx_data;
    sel_t  pv_addr;
    sel_t  pv_data;
    logic  emit;      // load the result register
    jmp_t  jmp;
    step_t target;
  } ctl_t;

  // Control store
  function automatic ctl_t ctl_rom(input step_t s);
    ctl_t c;
    c = '{ready: 1'b0, capture: 1'b0, load_pq: 1'b0, wr_en: 1'b0,
          nx_addr: SEL_N, nx_data: SEL_N, pv_addr: SEL_N, pv_data: SEL_N,
          emit: 1'b0, jmp: JMP_NEXT, target: ST_IDLE};
    case (s)
      ST_IDLE: begin
        c.ready  = 1'b1;
        c.jmp    = JMP_ACCEPT;
        c.target = ST_DECODE;
      end
      ST_DECODE: begin
        c.capture = 1'b1;
        c.jmp     = JMP_DISPATCH;
        c.target  = ST_UNL_A;
      end
      // next[prev(n)] = next(n); prev[next(n)] = prev(n)
      ST_UNL_A: begin
        c.wr_en   = 1'b1;
        c.nx_addr = SEL_NP;
        c.nx_data = SEL_NN;
        c.pv_addr = SEL_NN;
        c.pv_data = SEL_NP;
      end
      // node points to itself
      ST_UNL_B: begin
        c.wr_en   = 1'b1;
        c.nx_addr = SEL_N;
        c.nx_data = SEL_N;
        c.pv_addr = SEL_N;
        c.pv_data = SEL_N;
        c.jmp     = JMP_MOVE;
        c.target  = ST_DONE;
      end
      ST_ADD_PQ: begin
        c.load_pq = 1'b1;
      end
      // next[n] = q; prev[q] = n
      ST_ADD_A: begin
        c.wr_en   = 1'b1;
        c.nx_addr = SEL_N;
        c.nx_data = SEL_Q;
        c.pv_addr = SEL_Q;
        c.pv_data = SEL_N;
      end
      // next[p] = n; prev[n] = p
      ST_ADD_B: begin
        c.wr_en   = 1'b1;
        c.nx_addr = SEL_P;
        c.nx_data = SEL_N;
        c.pv_addr = SEL_N;
        c.pv_data = SEL_P;
      end
      ST_DONE: begin
        c.emit   = 1'b1;
        c.jmp    = JMP_OUT;
        c.target = ST_IDLE;
      end
      default: begin
        c.jmp    = JMP_OUT;
        c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/idll_in_if.sv
`timescale 1ns / 1ps

interface idll_in_if;
  import idll_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  cmd;
  node_t node_index;

  modport source (output valid, output cmd, output node_index, input ready);
  modport sink   (input valid, input cmd, input node_index, output ready);
endinterface

FILE: hw/rtl/idll_out_if.sv
`timescale 1ns / 1ps

interface idll_out_if;
  import idll_pkg::*;

  logic  valid;
  logic  ready;
  logic  applied;
  logic  list_empty;
  node_t first_index;
  node_t last_index;

  modport source (output valid, output applied, output list_empty,
                  output first_index, output last_index, input ready);
  modport sink   (input valid, input applied, input list_empty,
                  input first_index, input last_index, output ready);
endinterface

FILE: hw/rtl/indexed_doubly_linked_list.sv
`timescale 1ns / 1ps

// Circular doubly linked list of POOL_NODES nodes through root node 0, held in
// two link memories (next and prev); an unlinked node points to itself. Each
// input transaction carries a command (add at head/tail, move to head/tail,
// remove) and a node index; one result transaction follows with the applied
// flag and the list's empty flag, first and last index after the command. A
// small microprogram sequences the link memory accesses, one write per memory
// per cycle: a rejected command goes from decode to the result step, remove
// unlinks, add latches its neighbours and links, and move unlinks and re-adds.
// After reset a clearing pass writes every memory entry with its own index,
// accepting no input meanwhile. A finished result waits in an output register,
// so the next transaction is taken while the previous result is unclaimed.

module indexed_doubly_linked_list #(
  parameter int unsigned POOL_NODES = idll_pkg::POOL_NODES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  idll_in_if.sink    in_chan,
  idll_out_if.source out_chan
);
  import idll_pkg::*;

  localparam int unsigned IDX_W = $clog2(POOL_NODES);

  typedef logic [IDX_W-1:0] idx_t;

  // Link memories
  idx_t next_mem [POOL_NODES];
  idx_t prev_mem [POOL_NODES];

  // Sequencer and datapath registers
  step_t upc_r, upc_nxt;
  logic  clr_busy_r;
  idx_t  clr_cnt_r;
  cmd_t  cmd_r;
  idx_t  n_r;
  logic  n_ok_r;
  idx_t  rd_next_r, rd_prev_r;
  idx_t  nn_r, np_r, p_r, q_r;
  logic  ok_r;
  idx_t  root_next_r, root_prev_r;

  logic  out_valid_r;
  logic  out_applied_r;
  logic  out_empty_r;
  node_t out_first_r, out_last_r;

  ctl_t  ctl;
  logic  in_acc;
  logic  out_free;
  logic  guard;
  logic  is_add, is_move, at_head;
  logic  unl, lnk;
  idx_t  nx_waddr, nx_wdata, pv_waddr, pv_wdata;
  logic  mem_we;

  assign ctl = ctl_rom(upc_r);

  // Handshakes
  assign in_chan.ready = ctl.ready & ~clr_busy_r;
  assign in_acc        = in_chan.valid & in_chan.ready;
  assign out_free      = ~out_valid_r | out_chan.ready;

  // Command classes
  assign is_add  = (cmd_r == CMD_ADD_HEAD) || (cmd_r == CMD_ADD_TAIL);
  assign is_move = (cmd_r == CMD_MOVE_HEAD) || (cmd_r == CMD_MOVE_TAIL);
  assign at_head = (cmd_r == CMD_ADD_HEAD) || (cmd_r == CMD_MOVE_HEAD);

  // Guards on the node's freshly read links
  assign unl = (rd_next_r == n_r) && (rd_prev_r == n_r);
  assign lnk = (rd_next_r != n_r) && (rd_prev_r != n_r);

  always_comb begin
    case (cmd_r)
      CMD_ADD_HEAD, CMD_ADD_TAIL: guard = unl;
      CMD_MOVE_HEAD:              guard = lnk && (rd_next_r != rd_prev_r) &&
                                          (rd_prev_r != '0);
      CMD_MOVE_TAIL:              guard = lnk && (rd_next_r != rd_prev_r) &&
                                          (rd_next_r != '0);
      CMD_REMOVE:                 guard = lnk;
      default:                    guard = 1'b0;
    endcase
    guard = guard && n_ok_r && (n_r != '0);
  end

  // Next step
  always_comb begin
    case (ctl.jmp)
      JMP_NEXT:     upc_nxt = upc_r + step_t'(1);
      JMP_ACCEPT:   upc_nxt = in_acc ? ctl.target : upc_r;
      JMP_DISPATCH: begin
        if (!guard) begin
          upc_nxt = ST_DONE;
        end else if (is_add) begin
          upc_nxt = ST_ADD_PQ;
        end else begin
          upc_nxt = ctl.target;
        end
      end
      JMP_MOVE:     upc_nxt = is_move ? ST_ADD_PQ : ctl.target;
      JMP_OUT:      upc_nxt = out_free ? ctl.target : upc_r;
      default:      upc_nxt = ST_IDLE;
    endcase
  end

  // Operand selection for the write ports
  function automatic idx_t pick(input sel_t s, input idx_t n, input idx_t nn,
                                input idx_t np, input idx_t p, input idx_t q);
    idx_t v;
    case (s)
      SEL_N:   v = n;
      SEL_NN:  v = nn;
      SEL_NP:  v = np;
      SEL_P:   v = p;
      SEL_Q:   v = q;
      default: v = n;
    endcase
    return v;
  endfunction

  always_comb begin
    if (clr_busy_r) begin
      nx_waddr = clr_cnt_r;
      nx_wdata = clr_cnt_r;
      pv_waddr = clr_cnt_r;
      pv_wdata = clr_cnt_r;
      mem_we   = 1'b1;
    end else begin
      nx_waddr = pick(ctl.nx_addr, n_r, nn_r, np_r, p_r, q_r);
      nx_wdata = pick(ctl.nx_data, n_r, nn_r, np_r, p_r, q_r);
      pv_waddr = pick(ctl.pv_addr, n_r, nn_r, np_r, p_r, q_r);
      pv_wdata = pick(ctl.pv_data, n_r, nn_r, np_r, p_r, q_r);
      mem_we   = ctl.wr_en;
    end
  end

  // Link memories: one write, one registered read each
  always_ff @(posedge clk) begin
    if (mem_we) begin
      next_mem[nx_waddr] <= nx_wdata;
      prev_mem[pv_waddr] <= pv_wdata;
    end
    rd_next_r <= next_mem[idx_t'(in_chan.node_index)];
    rd_prev_r <= prev_mem[idx_t'(in_chan.node_index)];
  end

  // Sequencer, clearing pass and root links
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= ST_IDLE;
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      root_next_r <= '0;
      root_prev_r <= '0;
    end else begin
      upc_r <= upc_nxt;
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + idx_t'(1);
        if (clr_cnt_r == idx_t'(POOL_NODES - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end else if (ctl.wr_en) begin
        if (nx_waddr == '0) begin
          root_next_r <= nx_wdata;
        end
        if (pv_waddr == '0) begin
          root_prev_r <= pv_wdata;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_chan.cmd;
      n_r    <= idx_t'(in_chan.node_index);
      n_ok_r <= 32'(in_chan.node_index) < 32'(POOL_NODES);
    end
    if (ctl.capture) begin
      nn_r <= rd_next_r;
      np_r <= rd_prev_r;
      ok_r <= guard;
    end
    if (ctl.load_pq) begin
      p_r <= at_head ? '0 : root_prev_r;
      q_r <= at_head ? root_next_r : '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && out_free) begin
      out_applied_r <= ok_r;
      out_empty_r   <= (root_next_r == '0);
      out_first_r   <= node_t'(root_next_r);
      out_last_r    <= node_t'(root_prev_r);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.applied     = out_applied_r;
  assign out_chan.list_empty  = out_empty_r;
  assign out_chan.first_index = out_first_r;
  assign out_chan.last_index  = out_last_r;

endmodule

FILE: tb/list_link_checker.sv
`timescale 1ns / 1ps

module list_link_checker (
  input  logic            clk,
  input  logic            rst_n,
  idll_in_if              in_mon,
  idll_out_if             out_mon,
  output int unsigned     errors,
  output int unsigned     outstanding
);
  import idll_pkg::*;

  localparam int unsigned NODES = POOL_NODES_DEF;

  typedef struct packed {
    logic  applied;
    logic  list_empty;
    node_t first_index;
    node_t last_index;
  } list_status_t;

  // Shadow link memories
  node_t next_lk [NODES];
  node_t prev_lk [NODES];

  list_status_t pending_status [$];
  int unsigned  fail_cnt;

  initial begin
    errors      = 0;
    outstanding = 0;
    fail_cnt    = 0;
  end

  // Splice an unlinked node in at the head or the tail
  function automatic logic link_node(node_t n, logic at_head);
    node_t p;
    node_t q;
    if (n == '0 || next_lk[n] != n || prev_lk[n] != n) return 1'b0;
    if (at_head) begin
      if (prev_lk[n] == '0) return 1'b0;
      p = '0;
      q = next_lk[0];
    end else begin
      if (next_lk[n] == '0) return 1'b0;
      p = prev_lk[0];
      q = '0;
    end
    prev_lk[q] = n;
    next_lk[n] = q;
    prev_lk[n] = p;
    next_lk[p] = n;
    return 1'b1;
  endfunction

  function automatic void unlink_node(node_t n);
    node_t p;
    node_t q;
    p = prev_lk[n];
    q = next_lk[n];
    prev_lk[q] = p;
    next_lk[p] = q;
    next_lk[n] = n;
    prev_lk[n] = n;
  endfunction

  function automatic logic is_linked(node_t n);
    return n != '0 && next_lk[n] != n && prev_lk[n] != n;
  endfunction

  // Apply one command to the shadow list and report the resulting status
  function automatic list_status_t apply_list_cmd(cmd_t c, node_t n);
    list_status_t s;
    logic         done;
    done = 1'b0;
    case (c)
      CMD_ADD_HEAD: done = link_node(n, 1'b1);
      CMD_ADD_TAIL: done = link_node(n, 1'b0);
      CMD_MOVE_HEAD, CMD_MOVE_TAIL: begin
        // not a lone node, and not already at the requested end
        if (is_linked(n) && next_lk[n] != prev_lk[n] &&
            ((c == CMD_MOVE_HEAD) ? (prev_lk[n] != '0) : (next_lk[n] != '0))) begin
          unlink_node(n);
          done = link_node(n, c == CMD_MOVE_HEAD);
        end
      end
      CMD_REMOVE: begin
        if (is_linked(n)) begin
          unlink_node(n);
          done = 1'b1;
        end
      end
      default: done = 1'b0;
    endcase
    s.applied     = done;
    s.list_empty  = (next_lk[0] == '0);
    s.first_index = next_lk[0];
    s.last_index  = prev_lk[0];
    return s;
  endfunction

  // Compare results first, then record the new expectation
  always @(posedge clk) begin
    list_status_t want;
    list_status_t got;
    if (!rst_n) begin
      for (int unsigned i = 0; i < NODES; i++) begin
        next_lk[i] = node_t'(i);
        prev_lk[i] = node_t'(i);
      end
      pending_status.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.applied     = out_mon.applied;
        got.list_empty  = out_mon.list_empty;
        got.first_index = out_mon.first_index;
        got.last_index  = out_mon.last_index;
        if (pending_status.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected result applied=%0b empty=%0b first=%0d last=%0d",
                     $realtime, got.applied, got.list_empty, got.first_index,
                     got.last_index);
        end else begin
          want = pending_status.pop_front();
          if (got.applied !== want.applied || got.list_empty !== want.list_empty ||
              got.first_index !== want.first_index ||
              got.last_index !== want.last_index) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: exp %0b %0b %0d %0d | got %0b %0b %0d %0d",
                       $realtime, want.applied, want.list_empty, want.first_index,
                       want.last_index, got.applied, got.list_empty,
                       got.first_index, got.last_index);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        pending_status.push_back(apply_list_cmd(in_mon.cmd, in_mon.node_index));
    end
    errors      <= fail_cnt;
    outstanding <= pending_status.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import idll_pkg::*;

  // Codes the block must reject
  localparam cmd_t CMD_RSVD_5 = 3'd5;
  localparam cmd_t CMD_RSVD_6 = 3'd6;
  localparam cmd_t CMD_RSVD_7 = 3'd7;

  localparam node_t LAST_NODE = node_t'(POOL_NODES_DEF - 1);

  logic        clk;
  logic        rst_n;
  int unsigned err_total;
  int unsigned pending_results;
  int unsigned items_sent;
  logic        no_idle;
  logic        long_hold_done;

  idll_in_if  in_chan ();
  idll_out_if out_chan ();

  indexed_doubly_linked_list DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  list_link_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .errors      (err_total),
    .outstanding (pending_results)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Mostly no gap, some short ones, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_cmd(input cmd_t c, input node_t n);
    int unsigned gap;
    gap = no_idle ? 0 : idle_len();
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.cmd        <= c;
    in_chan.node_index <= n;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
  endtask

  // Random commands, mostly over nodes 1..span, with the add share set by add_pct
  task automatic random_batch(input int unsigned count, input int unsigned span,
                              input int unsigned add_pct);
    int unsigned r;
    cmd_t        c;
    node_t       n;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(99, 0);
      if (r < 3)
        c = cmd_t'($urandom_range(CMD_RSVD_7, CMD_RSVD_5));
      else if (r < 3 + add_pct)
        c = $urandom_range(1, 0) ? CMD_ADD_HEAD : CMD_ADD_TAIL;
      else if (r < 38 + add_pct)
        c = $urandom_range(1, 0) ? CMD_MOVE_HEAD : CMD_MOVE_TAIL;
      else
        c = CMD_REMOVE;
      r = $urandom_range(99, 0);
      if (r < 3)
        n = '0;
      else if (r < 8)
        n = node_t'($urandom_range(POOL_NODES_DEF - 1, 0));
      else
        n = node_t'($urandom_range(span, 1));
      send_cmd(c, n);
    end
  endtask

  // Result side: random back-pressure plus one long hold-off
  initial begin
    int unsigned stall;
    out_chan.ready = 1'b0;
    long_hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && items_sent >= 700) begin
        long_hold_done = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        stall = no_idle ? 0 : idle_len();
        if (stall != 0) begin
          out_chan.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end else begin
          out_chan.ready <= 1'b1;
          repeat ($urandom_range(6, 1)) @(posedge clk);
        end
      end
    end
  end

  // Command side and verdict
  initial begin
    int unsigned spans [4];
    int unsigned biases [3];
    spans  = '{3, 12, 40, 200};
    biases = '{20, 35, 55};
    rst_n              = 1'b0;
    items_sent         = 0;
    no_idle            = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.cmd        = CMD_ADD_HEAD;
    in_chan.node_index = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: rejects on an empty list, then build and reshuffle
    send_cmd(CMD_REMOVE,    node_t'(5));     // remove of an unlinked node
    send_cmd(CMD_ADD_HEAD,  '0);             // root is never a target
    send_cmd(CMD_ADD_HEAD,  node_t'(1));
    send_cmd(CMD_MOVE_HEAD, node_t'(1));     // lone node cannot move
    send_cmd(CMD_MOVE_TAIL, node_t'(1));
    send_cmd(CMD_ADD_HEAD,  node_t'(1));     // already linked
    send_cmd(CMD_ADD_TAIL,  LAST_NODE);
    send_cmd(CMD_MOVE_HEAD, node_t'(1));     // already first
    send_cmd(CMD_MOVE_TAIL, LAST_NODE);      // already last
    send_cmd(CMD_MOVE_TAIL, node_t'(1));
    send_cmd(CMD_ADD_TAIL,  node_t'(10'h2AA));
    send_cmd(CMD_ADD_HEAD,  node_t'(10'h155));
    send_cmd(CMD_MOVE_HEAD, node_t'(10'h2AA));
    send_cmd(CMD_MOVE_TAIL, node_t'(10'h155));
    send_cmd(CMD_MOVE_HEAD, '0);
    send_cmd(CMD_MOVE_TAIL, '0);
    send_cmd(CMD_ADD_TAIL,  '0);
    send_cmd(CMD_REMOVE,    '0);
    send_cmd(CMD_RSVD_5,    node_t'(1));
    send_cmd(CMD_RSVD_6,    LAST_NODE);
    send_cmd(CMD_RSVD_7,    LAST_NODE);
    send_cmd(CMD_REMOVE,    LAST_NODE);
    send_cmd(CMD_REMOVE,    LAST_NODE);      // second remove is rejected
    send_cmd(CMD_REMOVE,    node_t'(1));

    // Random phases with varying list sizes and add/remove balance
    for (int unsigned ph = 0; ph < 10; ph++) begin
      no_idle = (ph % 5 == 3);
      random_batch(200, spans[$urandom_range(3, 0)], biases[$urandom_range(2, 0)]);
    end
    no_idle = 1'b1;
    in_chan.valid <= 1'b0;

    // Drain, then watch for stray results
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (err_total == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
